// ----- rtl/oal_pkg.sv -----
// ---------------------------------------------------------------------------
// oal_pkg: shared types and codes for the ordered array list
// command and status codes, the cell operation type and fixed field widths
// ---------------------------------------------------------------------------
package oal_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned POSITION_W  = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // what every cell does on the broadcast operation
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_t;

endpackage

// ----- rtl/oal_cell.sv -----
// ---------------------------------------------------------------------------
// oal_cell: one list slot
// holds one entry and takes its left or right neighbor, the insert value or
// the head entry according to the broadcast operation and position
// ---------------------------------------------------------------------------
module oal_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned FCW = 5
) (
  input  logic                    clk,
  input  oal_pkg::cell_op_t       op,
  input  logic [FCW-1:0]          pos,
  input  logic signed [31:0]      left,
  input  logic signed [31:0]      right,
  input  logic signed [31:0]      head,
  input  logic signed [31:0]      ins_value,
  output logic signed [31:0]      q
);

  localparam logic [FCW-1:0] MY_IDX = FCW'(IDX);

  logic signed [31:0] q_next;

  always_comb begin
    q_next = q;
    unique case (op)
      oal_pkg::OP_HOLD: q_next = q;
      oal_pkg::OP_INS: begin
        if (MY_IDX > pos) begin
          q_next = left;
        end else if (MY_IDX == pos) begin
          q_next = ins_value;
        end
      end
      oal_pkg::OP_DEL: begin
        if (MY_IDX >= pos) begin
          q_next = right;
        end
      end
      oal_pkg::OP_ROT: begin
        // pos marks the last filled slot, which takes the head entry
        q_next = (MY_IDX == pos) ? head : right;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ----- rtl/ordered_array_list_unit.sv -----
// ---------------------------------------------------------------------------
// ordered_array_list_unit: bounded ordered list of signed 32-bit values
// a row of cells, one per slot, kept packed from slot 0
// ---------------------------------------------------------------------------
// usage:
//   slave channel s_* carries one command per beat; master channel m_*
//   returns the results. an insert, delete or unused command gives one
//   result beat with status and count; a dump gives one beat per held
//   entry (at most 16) in list order, or one empty-status beat on an
//   empty list. m_tlast marks the final beat of each command.
// timing:
//   insert and delete update the whole row at once: every cell compares its own
//   index with the position and shifts in parallel, and the result sits in
//   the output register in the cycle after the command beat.
//   a dump rotates the row one slot per cycle while the output is not stalled,
//   reading slot 0; the next command is taken after the rotation completes.
//   with a receiver that never stalls, non-dump commands run one per cycle.
// reset:
//   rst empties the list and drops m_tvalid; the entries are not cleared.
// stall:
//   while m_tvalid is high and m_tready low the output register holds its
//   beat, s_tready stays low and a dump pauses its rotation.
// ---------------------------------------------------------------------------
module ordered_array_list_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd[2:0], value[34:3], position[39:35]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], has_data[2], element[34:3], element_index[38:35],
  // count[43:39], zero fill[47:44]
  output logic [47:0] m_tdata,
  output logic        m_tlast
);

  localparam int unsigned FCW = $clog2(DEPTH + 1);
  localparam int unsigned CW  = (FCW > oal_pkg::POSITION_W) ? FCW : oal_pkg::POSITION_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t         state, state_next;
  logic [FCW-1:0] fill, fill_next;
  logic [FCW-1:0] dump_idx, dump_idx_next;

  // output register
  logic                 out_status_next_v;
  oal_pkg::status_t     out_status, res_status;
  logic                 out_has;
  logic signed [31:0]   out_elem;
  logic [3:0]           out_idx;
  logic [4:0]           out_count;
  logic                 out_last;

  // input beat fields
  oal_pkg::cmd_t        cmd;
  logic signed [31:0]   value;
  logic [4:0]           position;

  logic                 out_free;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [CW-1:0]        pos_ext;
  logic [CW-1:0]        fill_ext;
  logic [FCW-1:0]       fill_m1;

  // cell row control
  oal_pkg::cell_op_t    cell_op;
  logic [FCW-1:0]       cell_pos;
  logic signed [31:0]   cell_q [DEPTH];

  // dump step control
  logic                 dump_step;
  logic                 dump_emit;
  logic                 dump_last;
  logic                 load_status;

  assign cmd      = oal_pkg::cmd_t'(s_tdata[2:0]);
  assign value    = s_tdata[34:3];
  assign position = s_tdata[39:35];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  assign full     = (fill == FCW'(DEPTH));
  assign empty    = (fill == '0);
  assign pos_ext  = CW'(position);
  assign fill_ext = CW'(fill);
  assign fill_m1  = fill - FCW'(1);

  // a dump emits only the first entries but still rotates the whole ring
  assign dump_emit = (CW'(dump_idx) < CW'(oal_pkg::MAX_RESULTS));
  assign dump_last = (dump_idx == fill_m1) ||
                     (CW'(dump_idx) == CW'(oal_pkg::MAX_RESULTS - 1));
  assign dump_step = (state == S_DUMP) && (!dump_emit || out_free);

  // command decode and status
  always_comb begin
    cell_op           = oal_pkg::OP_HOLD;
    cell_pos          = fill_m1;
    res_status        = oal_pkg::ST_OK;
    load_status       = 1'b0;
    state_next        = state;
    dump_idx_next     = dump_idx;
    out_status_next_v = 1'b0;
    if (state == S_DUMP) begin
      if (dump_step) begin
        cell_op = oal_pkg::OP_ROT;
        if (dump_idx == fill_m1) begin
          dump_idx_next = '0;
          state_next    = S_IDLE;
        end else begin
          dump_idx_next = dump_idx + FCW'(1);
        end
      end
    end else if (accept) begin
      load_status = 1'b1;
      unique case (cmd)
        oal_pkg::CMD_INS_FRONT: begin
          if (full) begin
            res_status = oal_pkg::ST_FULL;
          end else begin
            cell_op  = oal_pkg::OP_INS;
            cell_pos = '0;
          end
        end
        oal_pkg::CMD_INS_END: begin
          if (full) begin
            res_status = oal_pkg::ST_FULL;
          end else begin
            cell_op  = oal_pkg::OP_INS;
            cell_pos = fill;
          end
        end
        oal_pkg::CMD_INS_POS: begin
          if (full) begin
            res_status = oal_pkg::ST_FULL;
          end else if (pos_ext > fill_ext) begin
            res_status = oal_pkg::ST_BADPOS;
          end else begin
            cell_op  = oal_pkg::OP_INS;
            cell_pos = FCW'(pos_ext);
          end
        end
        oal_pkg::CMD_DEL_FRONT: begin
          if (empty) begin
            res_status = oal_pkg::ST_EMPTY;
          end else begin
            cell_op  = oal_pkg::OP_DEL;
            cell_pos = '0;
          end
        end
        oal_pkg::CMD_DEL_END: begin
          if (empty) begin
            res_status = oal_pkg::ST_EMPTY;
          end else begin
            cell_op  = oal_pkg::OP_DEL;
            cell_pos = fill_m1;
          end
        end
        oal_pkg::CMD_DEL_POS: begin
          if (empty) begin
            res_status = oal_pkg::ST_EMPTY;
          end else if (pos_ext >= fill_ext) begin
            res_status = oal_pkg::ST_BADPOS;
          end else begin
            cell_op  = oal_pkg::OP_DEL;
            cell_pos = FCW'(pos_ext);
          end
        end
        oal_pkg::CMD_DUMP: begin
          if (empty) begin
            res_status = oal_pkg::ST_EMPTY;
          end else begin
            // entries come out of the rotation, not as a status beat
            load_status   = 1'b0;
            state_next    = S_DUMP;
            dump_idx_next = '0;
          end
        end
        default: res_status = oal_pkg::ST_OK;
      endcase
    end
    out_status_next_v = load_status;
  end

  always_comb begin
    fill_next = fill;
    if (cell_op == oal_pkg::OP_INS) begin
      fill_next = fill + FCW'(1);
    end else if (cell_op == oal_pkg::OP_DEL) begin
      fill_next = fill_m1;
    end
  end

  // row of cells: slot 0 faces the insert value, the last slot wraps to slot 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = cell_q[0];
    end else begin : g_mid_r
      assign right_in = cell_q[i+1];
    end
    oal_cell #(
      .IDX (i),
      .FCW (FCW)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .pos       (cell_pos),
      .left      (left_in),
      .right     (right_in),
      .head      (cell_q[0]),
      .ins_value (value),
      .q         (cell_q[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      dump_idx <= '0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      dump_idx <= dump_idx_next;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_status_next_v || (dump_step && dump_emit)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_status_next_v) begin
      out_status <= res_status;
      out_has    <= 1'b0;
      out_elem   <= '0;
      out_idx    <= '0;
      out_count  <= 5'(fill_next);
      out_last   <= 1'b1;
    end else if (dump_step && dump_emit) begin
      out_status <= oal_pkg::ST_OK;
      out_has    <= 1'b1;
      out_elem   <= cell_q[0];
      out_idx    <= 4'(dump_idx);
      out_count  <= 5'(fill);
      out_last   <= dump_last;
    end
  end

  assign m_tdata = {4'b0000, out_count, out_idx, out_elem, out_has, out_status};
  assign m_tlast = out_last;

endmodule

// ----- rtl/oal_checker.sv -----
// ---------------------------------------------------------------------------
// oal_checker: port-level checks on the ordered array list
// watches the result channel for beat shape and stall behavior
// ---------------------------------------------------------------------------
module oal_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat after reset");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

  // an entry beat always carries ok status
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] == oal_pkg::ST_OK)
    else $error("entry beat with bad status");

  // a status beat is single, with zero element and index
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tlast && m_tdata[38:3] == 36'd0)
    else $error("malformed status beat");

  // no new command is taken while a result waits on a stall
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("command taken while output stalled");

endmodule

bind ordered_array_list_unit oal_checker u_oal_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
